[sv/dccf_pkg.sv]
// Shared types, constants and length checks for the daisy-chain command framer.
package dccf_pkg;

  localparam int MAX_FRAME_BYTES    = 16;
  localparam int MAX_RESPONSE_BYTES = 256;
  localparam int NUM_DEVICES        = 2;

  localparam int SINGLE_HDR_BYTES = 6;
  localparam int BCAST_HDR_BYTES  = 5;
  localparam int MAX_DATA_BYTES   = 8;
  localparam int READ_OVERHEAD    = 6;

  // init, device, two address bytes and up to eight data bytes
  localparam int FRAME_BYTES = 4 + MAX_DATA_BYTES;
  localparam int LEN_W       = $clog2(FRAME_BYTES + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_WRITE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_READ   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_WRITE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_READ    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_WRITE = CFG_IDX_W'(4);

  localparam logic [7:0] RST_SINGLE_WRITE  = 8'h00;
  localparam logic [7:0] RST_SINGLE_READ   = 8'h90;
  localparam logic [7:0] RST_BCAST_WRITE   = 8'h00;
  localparam logic [7:0] RST_BCAST_READ    = 8'h80;
  localparam logic [7:0] RST_REVERSE_WRITE = 8'h00;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    CMD_SINGLE_WRITE  = 3'd0,
    CMD_SINGLE_READ   = 3'd1,
    CMD_BCAST_WRITE   = 3'd2,
    CMD_BCAST_READ    = 3'd3,
    CMD_REVERSE_WRITE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_ERR
  } state_e;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_CRC_LO,
    SEL_CRC_HI,
    SEL_ERR
  } out_sel_e;

  typedef struct packed {
    logic [7:0] single_write;
    logic [7:0] single_read;
    logic [7:0] bcast_write;
    logic [7:0] bcast_read;
    logic [7:0] reverse_write;
  } base_t;

  typedef struct packed {
    logic       bad;
    logic       is_write;
    logic       has_dev;
    logic [7:0] init;
  } dec_t;

  typedef struct packed {
    logic load;
    logic step;
  } step_ctl_t;

  typedef struct packed {
    logic [LEN_W-1:0] remaining;
    logic             last_byte;
  } shift_stat_t;

  typedef struct packed {
    logic     load;
    out_sel_e sel;
    logic     last;
  } out_ctl_t;

  function automatic logic write_len_bad(logic [7:0] n, logic [15:0] header);
    logic [15:0] total;
    total = {8'd0, n} + header;
    return (n == 8'd0) || (n > 8'(MAX_DATA_BYTES)) ||
           ((header != 16'd0) && (total > 16'(MAX_FRAME_BYTES)));
  endfunction

  function automatic logic single_read_bad(logic [7:0] n);
    logic [15:0] total;
    total = {8'd0, n} + 16'(READ_OVERHEAD);
    return (n == 8'd0) || (total > 16'(MAX_RESPONSE_BYTES));
  endfunction

  function automatic logic bcast_read_bad(logic [7:0] n);
    logic [15:0] total;
    total = 16'(NUM_DEVICES) * ({8'd0, n} + 16'(READ_OVERHEAD));
    return (n == 8'd0) || (total > 16'(MAX_RESPONSE_BYTES));
  endfunction

endpackage

[sv/daisy_chain_command_framer_top.sv]
// Daisy-chain command framer top level: stream ports, config port, output register.
// One command item is taken while the framer is idle; its frame then leaves one byte
// per cycle while the output is not stalled, from a byte-wide shift register, and a
// byte-serial CRC-16 follows it. A frame is 6 to 14 bytes; an invalid request gives
// a single error item instead. The next command is taken as soon as the final byte
// sits in the output register.
module daisy_chain_command_framer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // device_address[7:0], register_address[23:8], byte_count[31:24],
  // data_0[39:32] .. data_7[95:88]
  input  logic [95:0]                     s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // frame_byte[7:0]
  output logic [7:0]                      m_axis_tdata,
  output logic                            m_axis_tlast,
  // bad_request[0]
  output logic                            m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [dccf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dccf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import dccf_pkg::*;

  base_t       bases;
  dec_t        dec;
  step_ctl_t   step;
  shift_stat_t stat;
  out_ctl_t    out_ctl;
  state_e      state;
  logic [7:0]  shift_byte;
  logic [15:0] crc;
  logic        out_ready;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_last_q, out_last_d;
  logic        out_bad_q, out_bad_d;

  assign out_ready = !out_valid_q || m_axis_tready;

  dccf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bases_o     (bases)
  );

  dccf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .cmd_i        (s_axis_tuser),
    .byte_count_i (s_axis_tdata[31:24]),
    .bases_i      (bases),
    .stat_i       (stat),
    .out_ready_i  (out_ready),
    .in_ready_o   (s_axis_tready),
    .dec_o        (dec),
    .step_o       (step),
    .out_o        (out_ctl),
    .state_o      (state)
  );

  dccf_shifter u_shifter (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (step),
    .dec_i              (dec),
    .device_address_i   (s_axis_tdata[7:0]),
    .register_address_i (s_axis_tdata[23:8]),
    .byte_count_i       (s_axis_tdata[31:24]),
    .data_i             (s_axis_tdata[95:32]),
    .byte_o             (shift_byte),
    .stat_o             (stat)
  );

  dccf_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (step),
    .byte_i (shift_byte),
    .crc_o  (crc)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    if (out_ctl.load) begin
      out_valid_d = 1'b1;
      out_last_d  = out_ctl.last;
      out_bad_d   = 1'b0;
      unique case (out_ctl.sel)
        SEL_DATA:   out_data_d = shift_byte;
        SEL_CRC_LO: out_data_d = crc[7:0];
        SEL_CRC_HI: out_data_d = crc[15:8];
        SEL_ERR: begin
          out_data_d = 8'd0;
          out_bad_d  = 1'b1;
        end
      endcase
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

`ifndef ASSERT_OFF
  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("error item without last or with non-zero data");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state != ST_IDLE))
    else $error("accepted item produced no frame");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_DATA) |-> (stat.remaining != '0))
    else $error("frame byte phase with empty shift register");

  a_crc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_CRC_LO) |-> (stat.remaining == '0))
    else $error("CRC sent before all frame bytes");
`endif

endmodule

[sv/dccf_cfg.sv]
// Init byte base registers, written through the configuration port.
module dccf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dccf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dccf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output dccf_pkg::base_t                bases_o
);
  import dccf_pkg::*;

  base_t bases_q, bases_d;

  always_comb begin
    bases_d = bases_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SINGLE_WRITE:  bases_d.single_write  = cfg_wdata_i;
        CFG_SINGLE_READ:   bases_d.single_read   = cfg_wdata_i;
        CFG_BCAST_WRITE:   bases_d.bcast_write   = cfg_wdata_i;
        CFG_BCAST_READ:    bases_d.bcast_read    = cfg_wdata_i;
        CFG_REVERSE_WRITE: bases_d.reverse_write = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bases_q.single_write  <= RST_SINGLE_WRITE;
      bases_q.single_read   <= RST_SINGLE_READ;
      bases_q.bcast_write   <= RST_BCAST_WRITE;
      bases_q.bcast_read    <= RST_BCAST_READ;
      bases_q.reverse_write <= RST_REVERSE_WRITE;
    end else begin
      bases_q <= bases_d;
    end
  end

  assign bases_o = bases_q;

endmodule

[sv/dccf_shifter.sv]
// Frame byte shift register: loads the header and payload, emits one byte per step.
module dccf_shifter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dccf_pkg::step_ctl_t     ctl_i,
  input  dccf_pkg::dec_t          dec_i,
  input  logic [7:0]              device_address_i,
  input  logic [15:0]             register_address_i,
  input  logic [7:0]              byte_count_i,
  input  logic [63:0]             data_i,
  output logic [7:0]              byte_o,
  output dccf_pkg::shift_stat_t   stat_o
);
  import dccf_pkg::*;

  localparam int SHIFT_W = 8 * FRAME_BYTES;

  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [LEN_W-1:0]   remaining_q, remaining_d;
  logic [63:0]        tail;
  logic [SHIFT_W-1:0] frame;
  logic [LEN_W-1:0]   frame_len;

  always_comb begin
    tail = dec_i.is_write ? data_i : {56'd0, byte_count_i - 8'd1};
    if (dec_i.has_dev) begin
      frame = {tail, register_address_i[7:0], register_address_i[15:8],
               1'b0, device_address_i[6:0], dec_i.init};
    end else begin
      frame = {8'd0, tail, register_address_i[7:0], register_address_i[15:8],
               dec_i.init};
    end
    frame_len = (dec_i.has_dev ? LEN_W'(4) : LEN_W'(3)) +
                (dec_i.is_write ? LEN_W'(byte_count_i[3:0]) : LEN_W'(1));
  end

  always_comb begin
    shift_d     = shift_q;
    remaining_d = remaining_q;
    if (ctl_i.load) begin
      shift_d     = frame;
      remaining_d = frame_len;
    end else if (ctl_i.step) begin
      shift_d     = {8'd0, shift_q[SHIFT_W-1:8]};
      remaining_d = remaining_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
    end else begin
      remaining_q <= remaining_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign byte_o           = shift_q[7:0];
  assign stat_o.remaining = remaining_q;
  assign stat_o.last_byte = (remaining_q == LEN_W'(1));

endmodule

[sv/dccf_crc.sv]
// Reflected CRC-16 (0xA001) register, updated one frame byte per step.
module dccf_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dccf_pkg::step_ctl_t ctl_i,
  input  logic [7:0]          byte_i,
  output logic [15:0]         crc_o
);
  import dccf_pkg::*;

  logic [15:0] crc_q, crc_d;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.load) begin
      crc_d = CRC_INIT;
    end else if (ctl_i.step) begin
      crc_d = crc_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

[sv/dccf_ctrl.sv]
// Command decode and frame sequencer.
module dccf_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [2:0]              cmd_i,
  input  logic [7:0]              byte_count_i,
  input  dccf_pkg::base_t         bases_i,
  input  dccf_pkg::shift_stat_t   stat_i,
  input  logic                    out_ready_i,
  output logic                    in_ready_o,
  output dccf_pkg::dec_t          dec_o,
  output dccf_pkg::step_ctl_t     step_o,
  output dccf_pkg::out_ctl_t      out_o,
  output dccf_pkg::state_e        state_o
);
  import dccf_pkg::*;

  state_e state_q, state_d;
  dec_t   dec;
  logic   wlen_bad;

  always_comb begin
    dec      = '0;
    wlen_bad = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_SINGLE_WRITE: begin
        wlen_bad     = write_len_bad(byte_count_i, 16'(SINGLE_HDR_BYTES));
        dec.bad      = wlen_bad;
        dec.is_write = 1'b1;
        dec.has_dev  = 1'b1;
        dec.init     = bases_i.single_write;
      end
      CMD_SINGLE_READ: begin
        dec.bad     = single_read_bad(byte_count_i);
        dec.has_dev = 1'b1;
        dec.init    = bases_i.single_read;
      end
      CMD_BCAST_WRITE: begin
        wlen_bad     = write_len_bad(byte_count_i, 16'(BCAST_HDR_BYTES));
        dec.bad      = wlen_bad;
        dec.is_write = 1'b1;
        dec.init     = bases_i.bcast_write;
      end
      CMD_BCAST_READ: begin
        dec.bad  = bcast_read_bad(byte_count_i);
        dec.init = bases_i.bcast_read;
      end
      CMD_REVERSE_WRITE: begin
        wlen_bad     = write_len_bad(byte_count_i, 16'd0);
        dec.bad      = wlen_bad;
        dec.is_write = 1'b1;
        dec.init     = bases_i.reverse_write;
      end
      default: dec.bad = 1'b1;
    endcase
    if (dec.is_write) begin
      dec.init = dec.init | {5'd0, byte_count_i[2:0] - 3'd1};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = dec.bad ? ST_ERR : ST_DATA;
      ST_DATA:   if (out_ready_i && stat_i.last_byte) state_d = ST_CRC_LO;
      ST_CRC_LO: if (out_ready_i) state_d = ST_CRC_HI;
      ST_CRC_HI: if (out_ready_i) state_d = ST_IDLE;
      ST_ERR:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    step_o      = '0;
    out_o.load  = 1'b0;
    out_o.sel   = SEL_DATA;
    out_o.last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        step_o.load = in_valid_i;
      end
      ST_DATA: begin
        step_o.step = out_ready_i;
        out_o.load  = out_ready_i;
      end
      ST_CRC_LO: begin
        out_o.load = out_ready_i;
        out_o.sel  = SEL_CRC_LO;
      end
      ST_CRC_HI: begin
        out_o.load = out_ready_i;
        out_o.sel  = SEL_CRC_HI;
        out_o.last = 1'b1;
      end
      ST_ERR: begin
        out_o.load = out_ready_i;
        out_o.sel  = SEL_ERR;
        out_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign dec_o   = dec;
  assign state_o = state_q;

endmodule
